FILE: hw/rtl/atapio_pkg.sv
// Shared types, constants and result-list helpers for the ATA PIO transfer sequencer.
package atapio_pkg;

   localparam int SECTOR_WORDS_DEF        = 256;
   localparam int MAX_SECTORS_PER_CMD_DEF = 256;
   localparam int MAX_BLOCK_DEF           = 128;
   localparam int LIST_DEPTH              = 6;

   // request commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_DATA  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_REG  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // result codes
   localparam logic [2:0] RES_OK        = 3'd0;
   localparam logic [2:0] RES_RANGE     = 3'd1;
   localparam logic [2:0] RES_TIMEOUT   = 3'd2;
   localparam logic [2:0] RES_NO_DRQ    = 3'd3;
   localparam logic [2:0] RES_DRQ_AFTER = 3'd4;
   localparam logic [2:0] RES_WFAULT    = 3'd5;
   localparam logic [2:0] RES_DEV_ERR   = 3'd6;

   // task file register indexes
   localparam logic [3:0] TF_SC   = 4'd2;
   localparam logic [3:0] TF_SN   = 4'd3;
   localparam logic [3:0] TF_CL   = 4'd4;
   localparam logic [3:0] TF_CH   = 4'd5;
   localparam logic [3:0] TF_DH   = 4'd6;
   localparam logic [3:0] TF_CMD  = 4'd7;
   localparam logic [3:0] TF_DCTL = 4'd8;

   // status bits
   localparam int ST_BSY = 7;
   localparam int ST_DWF = 5;
   localparam int ST_DRQ = 3;
   localparam int ST_ERR = 0;

   localparam logic [7:0] DH_LBA_MODE   = 8'hE0;
   localparam logic [7:0] DC_SRST       = 8'h04;
   localparam logic [7:0] ATA_READ_SEC  = 8'h20;
   localparam logic [7:0] ATA_WRITE_SEC = 8'h30;
   localparam logic [7:0] ATA_READ_MUL  = 8'hC4;
   localparam logic [7:0] ATA_WRITE_MUL = 8'hC5;
   localparam logic [7:0] ATA_SET_MUL   = 8'hC6;

   // register indexes on the configuration port
   localparam logic [1:0] CSR_BLOCK_SIZE    = 2'd0;
   localparam logic [1:0] CSR_TOTAL_SECTORS = 2'd1;
   localparam logic [1:0] CSR_CMD_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_RST_TIMEOUT   = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_RESET,
      PH_WAIT_MULT,
      PH_WAIT_CMD,
      PH_DATA,
      PH_WAIT_BLOCK
   } phase_type;

   typedef struct packed {
      logic [7:0]  block_size;
      logic [27:0] total_sectors;
      logic [25:0] cmd_timeout;
      logic [25:0] reset_timeout;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  reg_index;
      logic [7:0]  reg_value;
      logic [15:0] word;
      logic [2:0]  code;
      logic [7:0]  err;
   } rsp_entry_type;

   typedef struct packed {
      logic [2:0]                           count;
      rsp_entry_type [LIST_DEPTH-1:0]       entry;
   } rsp_list_type;

   function automatic rsp_list_type push(rsp_list_type l, rsp_entry_type e);
      rsp_list_type r;
      r = l;
      r.entry[l.count] = e;
      r.count = l.count + 3'd1;
      return r;
   endfunction

   function automatic rsp_entry_type mk_reg(logic [3:0] idx, logic [7:0] val);
      rsp_entry_type e;
      e = '0;
      e.kind      = KIND_REG;
      e.reg_index = idx;
      e.reg_value = val;
      return e;
   endfunction

   function automatic rsp_entry_type mk_done(logic [2:0] code, logic [7:0] err);
      rsp_entry_type e;
      e = '0;
      e.kind = KIND_DONE;
      e.code = code;
      e.err  = err;
      return e;
   endfunction

   function automatic rsp_entry_type mk_data(logic [15:0] w);
      rsp_entry_type e;
      e = '0;
      e.kind = KIND_DATA;
      e.word = w;
      return e;
   endfunction

   // task file writes and the command for one transfer
   function automatic rsp_list_type issue(rsp_list_type l, logic [27:0] lba,
                                          logic [8:0] cnt, logic rd, logic multi);
      rsp_list_type r;
      logic [7:0]   op;
      r = l;
      if (multi) op = rd ? ATA_READ_MUL : ATA_WRITE_MUL;
      else       op = rd ? ATA_READ_SEC : ATA_WRITE_SEC;
      if (cnt != 9'd0) begin
         r = push(r, mk_reg(TF_SC, cnt[7:0]));
         r = push(r, mk_reg(TF_SN, lba[7:0]));
         r = push(r, mk_reg(TF_CL, lba[15:8]));
         r = push(r, mk_reg(TF_CH, lba[23:16]));
      end
      r = push(r, mk_reg(TF_DH, {4'h0, lba[27:24]} | DH_LBA_MODE));
      r = push(r, mk_reg(TF_CMD, op));
      return r;
   endfunction

endpackage

FILE: hw/rtl/atapio_csr.sv
// Configuration registers behind the APB-style port.
module atapio_csr
   import atapio_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            CSR_BLOCK_SIZE:    cfg_in.block_size    = csr_pwdata[7:0];
            CSR_TOTAL_SECTORS: cfg_in.total_sectors = csr_pwdata[27:0];
            CSR_CMD_TIMEOUT:   cfg_in.cmd_timeout   = csr_pwdata[25:0];
            CSR_RST_TIMEOUT:   cfg_in.reset_timeout = csr_pwdata[25:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_BLOCK_SIZE:    csr_prdata = {24'd0, cfg_ff.block_size};
         CSR_TOTAL_SECTORS: csr_prdata = {4'd0, cfg_ff.total_sectors};
         CSR_CMD_TIMEOUT:   csr_prdata = {6'd0, cfg_ff.cmd_timeout};
         CSR_RST_TIMEOUT:   csr_prdata = {6'd0, cfg_ff.reset_timeout};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size    <= 8'd1;
         cfg_ff.total_sectors <= 28'd0;
         cfg_ff.cmd_timeout   <= 26'd10000000;
         cfg_ff.reset_timeout <= 26'd30000000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/atapio_core.sv
// Sequencer state and the per-item result list.
module atapio_core
   import atapio_pkg::*;
#(
   parameter int SECTOR_WORDS        = SECTOR_WORDS_DEF,
   parameter int MAX_SECTORS_PER_CMD = MAX_SECTORS_PER_CMD_DEF,
   parameter int MAX_BLOCK           = MAX_BLOCK_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         accept,
   input  logic [1:0]   req_command,
   input  logic [27:0]  req_lba,
   input  logic [8:0]   req_sector_count,
   input  logic         req_is_read,
   input  logic [7:0]   req_device_status,
   input  logic [7:0]   req_device_error,
   input  logic [15:0]  req_data_word,
   output rsp_list_type list
);

   localparam int WW = $clog2(SECTOR_WORDS + 1);
   localparam int BW = $clog2(MAX_BLOCK + 1);

   phase_type     phase_ff, phase_in;
   logic [25:0]   wait_ff, wait_in;
   logic          skip_ff, skip_in;
   logic [8:0]    left_ff, left_in;
   logic [BW-1:0] sib_ff, sib_in;
   logic [WW-1:0] wis_ff, wis_in;
   logic [27:0]   lba_ff, lba_in;
   logic [8:0]    cnt_ff, cnt_in;
   logic          dir_ff, dir_in;

   logic [7:0]    eff;
   logic          multi;
   logic [25:0]   wait_inc;
   logic [25:0]   limit;
   logic [WW-1:0] wis_inc;
   logic [BW-1:0] sib_inc;
   logic [8:0]    left_dec;
   logic          waiting;

   always_comb begin
      eff = (cfg.block_size == 8'd0) ? 8'd1 : cfg.block_size;
      if (eff > 8'(MAX_BLOCK)) eff = 8'(MAX_BLOCK);
   end

   assign multi    = (eff != 8'd1);
   assign wait_inc = wait_ff + 26'd1;
   assign limit    = (phase_ff == PH_WAIT_RESET) ? cfg.reset_timeout : cfg.cmd_timeout;
   assign wis_inc  = wis_ff + WW'(1);
   assign sib_inc  = sib_ff + BW'(1);
   assign left_dec = (left_ff != 9'd0) ? left_ff - 9'd1 : left_ff;
   assign waiting  = (phase_ff == PH_WAIT_RESET) || (phase_ff == PH_WAIT_MULT) ||
                     (phase_ff == PH_WAIT_CMD) || (phase_ff == PH_WAIT_BLOCK);

   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      skip_in  = skip_ff;
      left_in  = left_ff;
      sib_in   = sib_ff;
      wis_in   = wis_ff;
      lba_in   = lba_ff;
      cnt_in   = cnt_ff;
      dir_in   = dir_ff;
      list     = '0;
      case (req_command)
         CMD_START: begin
            lba_in  = req_lba;
            cnt_in  = req_sector_count;
            dir_in  = req_is_read;
            left_in = req_sector_count;
            sib_in  = '0;
            wis_in  = '0;
            skip_in = 1'b1;
            wait_in = '0;
            if ((req_sector_count > 9'(MAX_SECTORS_PER_CMD)) ||
                (({1'b0, req_lba} + {20'd0, req_sector_count}) >
                 {1'b0, cfg.total_sectors})) begin
               list     = push(list, mk_done(RES_RANGE, 8'd0));
               phase_in = PH_IDLE;
               skip_in  = 1'b0;
            end else if (req_device_status[ST_BSY]) begin
               list     = push(list, mk_reg(TF_DCTL, DC_SRST));
               list     = push(list, mk_reg(TF_DCTL, 8'd0));
               phase_in = PH_WAIT_RESET;
            end else begin
               list     = issue(list, req_lba, req_sector_count, req_is_read, multi);
               phase_in = PH_WAIT_CMD;
            end
         end
         CMD_TICK: begin
            if (waiting) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else if (req_device_status[ST_BSY]) begin
                  wait_in = wait_inc;
                  if (wait_inc >= limit) begin
                     list     = push(list, mk_done(RES_TIMEOUT, 8'd0));
                     phase_in = PH_IDLE;
                     wait_in  = '0;
                  end
               end else if (phase_ff == PH_WAIT_RESET) begin
                  skip_in = 1'b1;
                  wait_in = '0;
                  if (multi) begin
                     list     = push(list, mk_reg(TF_SC, eff));
                     list     = push(list, mk_reg(TF_DH, DH_LBA_MODE));
                     list     = push(list, mk_reg(TF_CMD, ATA_SET_MUL));
                     phase_in = PH_WAIT_MULT;
                  end else begin
                     list     = issue(list, lba_ff, cnt_ff, dir_ff, multi);
                     phase_in = PH_WAIT_CMD;
                  end
               end else if (phase_ff == PH_WAIT_MULT) begin
                  list     = issue(list, lba_ff, cnt_ff, dir_ff, multi);
                  phase_in = PH_WAIT_CMD;
                  skip_in  = 1'b1;
                  wait_in  = '0;
               end else if (left_ff != 9'd0) begin
                  if (!req_device_status[ST_DRQ]) begin
                     list = push(list, mk_done(RES_NO_DRQ, req_device_status[ST_ERR] ?
                                                           req_device_error : 8'd0));
                     phase_in = PH_IDLE;
                     wait_in  = '0;
                  end else begin
                     phase_in = PH_DATA;
                     sib_in   = '0;
                     wis_in   = '0;
                  end
               end else begin
                  phase_in = PH_IDLE;
                  wait_in  = '0;
                  if (req_device_status[ST_DRQ])
                     list = push(list, mk_done(RES_DRQ_AFTER, 8'd0));
                  else if (req_device_status[ST_DWF])
                     list = push(list, mk_done(RES_WFAULT, 8'd0));
                  else if (req_device_status[ST_ERR])
                     list = push(list, mk_done(RES_DEV_ERR, req_device_error));
                  else
                     list = push(list, mk_done(RES_OK, 8'd0));
               end
            end
         end
         CMD_DATA: begin
            if (phase_ff == PH_DATA) begin
               list   = push(list, mk_data(req_data_word));
               wis_in = wis_inc;
               if (wis_inc >= WW'(SECTOR_WORDS)) begin
                  wis_in  = '0;
                  left_in = left_dec;
                  sib_in  = sib_inc;
                  // block done: wait for the device to turn around
                  if ((8'(sib_inc) >= eff) || (left_dec == 9'd0)) begin
                     phase_in = PH_WAIT_BLOCK;
                     skip_in  = 1'b1;
                     wait_in  = '0;
                  end
               end
            end
         end
         default: list = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         skip_ff  <= 1'b0;
         left_ff  <= '0;
         sib_ff   <= '0;
         wis_ff   <= '0;
         lba_ff   <= '0;
         cnt_ff   <= '0;
         dir_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         skip_ff  <= skip_in;
         left_ff  <= left_in;
         sib_ff   <= sib_in;
         wis_ff   <= wis_in;
         lba_ff   <= lba_in;
         cnt_ff   <= cnt_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

FILE: hw/rtl/atapio_out.sv
// Result list register, drained one result per transfer.
module atapio_out
   import atapio_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_list_type list,
   output logic         can_load,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_kind,
   output logic [3:0]   rsp_reg_index,
   output logic [7:0]   rsp_reg_value,
   output logic [15:0]  rsp_word_out,
   output logic [2:0]   rsp_result_code,
   output logic [7:0]   rsp_error_byte,
   output logic         rsp_last
);

   rsp_entry_type [LIST_DEPTH-1:0] entry_ff;
   logic [2:0]    count_ff, count_in;
   logic [2:0]    idx_ff, idx_in;
   logic          take;
   logic          at_last;
   rsp_entry_type cur;

   assign rsp_valid = (count_ff != 3'd0);
   assign take      = rsp_valid & ~rsp_stall;
   assign at_last   = (idx_ff == count_ff - 3'd1);
   assign can_load  = ~rsp_valid | (take & at_last);
   assign cur       = entry_ff[idx_ff];

   assign rsp_kind        = cur.kind;
   assign rsp_reg_index   = cur.reg_index;
   assign rsp_reg_value   = cur.reg_value;
   assign rsp_word_out    = cur.word;
   assign rsp_result_code = cur.code;
   assign rsp_error_byte  = cur.err;
   assign rsp_last        = at_last;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (load) begin
         count_in = list.count;
         idx_in   = 3'd0;
      end else if (take) begin
         if (at_last) count_in = 3'd0;
         else         idx_in   = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 3'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) entry_ff <= list.entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(LIST_DEPTH)) else $error("result count overflow");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < count_ff)) else $error("result index past end");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !at_last && !load) |=> rsp_valid)
      else $error("results dropped before last");

   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load) else $error("list loaded over pending results");

endmodule

FILE: hw/rtl/ata_pio_transfer_sequencer.sv
// Host-side ATA PIO LBA28 transfer sequencer: top level.
// Each accepted input item is turned into a list of zero to six results
// (task-file writes, a forwarded data word or a done code) held in the output list
// register. Results leave one per cycle while rsp_stall is low; the next item is taken
// in the same cycle that the last result of the previous one is transferred, or at
// once when no results are pending; until then req_stall holds the input. Data words, and
// status ticks outside the soft-reset and SET MULTIPLE waits, give at most one result
// each and run at one item per cycle while rsp_stall is low; a start or a tick that
// ends the soft-reset or SET MULTIPLE wait gives up to six results, stalling the input.
module ata_pio_transfer_sequencer
   import atapio_pkg::*;
#(
   parameter int SECTOR_WORDS        = SECTOR_WORDS_DEF,
   parameter int MAX_SECTORS_PER_CMD = MAX_SECTORS_PER_CMD_DEF,
   parameter int MAX_BLOCK           = MAX_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [27:0] req_lba,
   input  logic [8:0]  req_sector_count,
   input  logic        req_is_read,
   input  logic [7:0]  req_device_status,
   input  logic [7:0]  req_device_error,
   input  logic [15:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_reg_index,
   output logic [7:0]  rsp_reg_value,
   output logic [15:0] rsp_word_out,
   output logic [2:0]  rsp_result_code,
   output logic [7:0]  rsp_error_byte,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type      cfg;
   rsp_list_type list;
   logic         can_load;
   logic         accept;

   assign req_stall = ~can_load;
   assign accept    = req_valid & can_load;

   atapio_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   atapio_core #(
      .SECTOR_WORDS        (SECTOR_WORDS),
      .MAX_SECTORS_PER_CMD (MAX_SECTORS_PER_CMD),
      .MAX_BLOCK           (MAX_BLOCK)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .accept            (accept),
      .req_command       (req_command),
      .req_lba           (req_lba),
      .req_sector_count  (req_sector_count),
      .req_is_read       (req_is_read),
      .req_device_status (req_device_status),
      .req_device_error  (req_device_error),
      .req_data_word     (req_data_word),
      .list              (list)
   );

   atapio_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .list            (list),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_reg_index   (rsp_reg_index),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_word_out    (rsp_word_out),
      .rsp_result_code (rsp_result_code),
      .rsp_error_byte  (rsp_error_byte),
      .rsp_last        (rsp_last)
   );

endmodule
